@@ design/sem_pkg.sv @@
// Shared types, constants and command structs of the Sobel edge magnitude block.
`default_nettype none

package sem_pkg;

  // Default line store depth and frame height limit
  localparam int DEF_MAX_WIDTH  = 2048;
  localparam int DEF_MAX_HEIGHT = 4096;

  // Field widths
  localparam int PIX_BITS      = 8;
  localparam int FW_BITS       = 12;
  localparam int FH_BITS       = 13;
  localparam int CFG_DATA_BITS = 13;

  // Register values after reset
  localparam int RESET_FRAME_WIDTH  = 1920;
  localparam int RESET_FRAME_HEIGHT = 1080;
  localparam int MIN_SIZE           = 3;

  // Gradient arithmetic: |Hh|,|Hv| <= 1020, squares < 2^20, S < 2^21
  localparam int GRAD_BITS = 11;
  localparam int SQ_BITS   = 20;
  localparam int SUM_BITS  = 21;
  localparam int FRAC_BITS = 16;
  localparam int RAD_BITS  = SUM_BITS + FRAC_BITS;
  // Top bit of the root search; must be an even power
  localparam int ROOT_TOP  = RAD_BITS - 1;
  localparam int ROOT_BITS = 19;

  // Scaling by 1/1140 as multiply by ceil(2^30/1140), then one correction
  localparam int SCALE_DIV   = 1140;
  localparam int DIV_BITS    = 11;
  localparam int RECIP       = 941879;
  localparam int RECIP_BITS  = 20;
  localparam int RECIP_SHIFT = 30;
  localparam int Q_BITS      = ROOT_BITS + RECIP_BITS - RECIP_SHIFT;
  localparam int MAG_MAX     = 255;

  // Configuration register indexes
  typedef enum logic [0:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_t;

  // Controller states
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_UPDATE,
    ST_SQUARE,
    ST_SUM,
    ST_ROOT,
    ST_SCALE,
    ST_FIX,
    ST_EMIT
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic clear;
    logic load;
    logic read;
    logic update;
    logic square;
    logic sum;
    logic root_step;
    logic scale;
    logic fix;
    logic emit;
  } dp_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic clear_done;
    logic interior;
    logic root_last;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

@@ design/sem_if.sv @@
// Channel interfaces: pixel stream, result stream and configuration writes.
`default_nettype none

interface sem_pix_if import sem_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [PIX_BITS-1:0] pixel;
  logic                frame_start;

  modport source (output valid, output pixel, output frame_start, input ready);
  modport sink   (input valid, input pixel, input frame_start, output ready);
endinterface

interface sem_res_if import sem_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [PIX_BITS-1:0] magnitude;
  logic                frame_last;

  modport source (output valid, output magnitude, output frame_last, input ready);
  modport sink   (input valid, input magnitude, input frame_last, output ready);
endinterface

interface sem_cfg_if import sem_pkg::*; ();
  logic                     valid;
  logic                     ready;
  cfg_reg_t                 index;
  logic [CFG_DATA_BITS-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ design/sem_ctrl.sv @@
// Controller state machine that sequences the Sobel datapath.
`default_nettype none

module sem_ctrl import sem_pkg::*; (
  input  wire        clk,
  input  wire        rst,
  input  wire        pix_valid,
  output logic       pix_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  state_t state, state_next;

  // Hold or advance the state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR:  if (status.clear_done) state_next = ST_IDLE;
      ST_IDLE:   if (pix_valid) state_next = ST_READ;
      ST_READ:   state_next = ST_UPDATE;
      ST_UPDATE: state_next = status.interior ? ST_SQUARE : ST_IDLE;
      ST_SQUARE: state_next = ST_SUM;
      ST_SUM:    state_next = ST_ROOT;
      ST_ROOT:   if (status.root_last) state_next = ST_SCALE;
      ST_SCALE:  state_next = ST_FIX;
      ST_FIX:    state_next = ST_EMIT;
      ST_EMIT:   if (status.out_free) state_next = ST_IDLE;
      default:   state_next = ST_CLEAR;
    endcase
  end

  // Commands for the current state
  always_comb begin
    cmd       = '0;
    pix_ready = 1'b0;
    unique case (state)
      ST_CLEAR:  cmd.clear = 1'b1;
      ST_IDLE: begin
        pix_ready = 1'b1;
        cmd.load  = pix_valid;
      end
      ST_READ:   cmd.read = 1'b1;
      ST_UPDATE: cmd.update = 1'b1;
      ST_SQUARE: cmd.square = 1'b1;
      ST_SUM:    cmd.sum = 1'b1;
      ST_ROOT:   cmd.root_step = 1'b1;
      ST_SCALE:  cmd.scale = 1'b1;
      ST_FIX:    cmd.fix = 1'b1;
      ST_EMIT:   cmd.emit = status.out_free;
      default:   cmd = '0;
    endcase
  end

endmodule

`default_nettype wire

@@ design/sem_dp.sv @@
// Datapath: line stores, 3x3 window, position counters, root and scaling unit.
`default_nettype none

module sem_dp import sem_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  wire                      clk,
  input  wire                      rst,
  input  dp_cmd_t                  cmd,
  output dp_status_t               status,
  input  wire [PIX_BITS-1:0]       pixel,
  input  wire                      frame_start,
  input  wire                      cfg_valid,
  input  cfg_reg_t                 cfg_index,
  input  wire [CFG_DATA_BITS-1:0]  cfg_data,
  input  wire                      res_ready,
  output logic                     res_valid,
  output logic [PIX_BITS-1:0]      magnitude,
  output logic                     frame_last
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int WW = (CW + 1 > FW_BITS) ? CW + 1 : FW_BITS;
  localparam int HW = (RW + 1 > FH_BITS) ? RW + 1 : FH_BITS;

  // Configuration registers
  logic [FW_BITS-1:0] frame_width;
  logic [FH_BITS-1:0] frame_height;

  // Position of the incoming pixel
  logic [CW-1:0] column_count;
  logic [RW-1:0] row_count;
  logic [CW-1:0] clr_addr;

  // Line stores and window
  logic [PIX_BITS-1:0] older_line [MAX_WIDTH];
  logic [PIX_BITS-1:0] newer_line [MAX_WIDTH];
  logic [PIX_BITS-1:0] win [6];
  logic [PIX_BITS-1:0] pix_q, top_q, mid_q;
  logic                last_q;

  // Arithmetic registers
  logic signed [GRAD_BITS-1:0] gh, gv;
  logic [SQ_BITS-1:0]          sq_h, sq_v;
  logic [RAD_BITS-1:0]         rem, root, bitm;
  logic [Q_BITS-1:0]           q_est;
  logic [PIX_BITS-1:0]         mag_q;

  // Effective sizes and end-of-row / end-of-frame tests
  logic [WW-1:0] fw_ext, w_eff, col_inc;
  logic [HW-1:0] fh_ext, h_eff, row_inc;
  logic          row_end, frame_end;

  always_comb begin
    fw_ext = WW'(frame_width);
    fh_ext = HW'(frame_height);
    if (fw_ext < WW'(MIN_SIZE))       w_eff = WW'(MIN_SIZE);
    else if (fw_ext > WW'(MAX_WIDTH)) w_eff = WW'(MAX_WIDTH);
    else                              w_eff = fw_ext;
    if (fh_ext < HW'(MIN_SIZE))        h_eff = HW'(MIN_SIZE);
    else if (fh_ext > HW'(MAX_HEIGHT)) h_eff = HW'(MAX_HEIGHT);
    else                               h_eff = fh_ext;
    col_inc   = WW'(column_count) + WW'(1);
    row_inc   = HW'(row_count) + HW'(1);
    row_end   = col_inc >= w_eff;
    frame_end = row_inc >= h_eff;
  end

  assign status.clear_done = clr_addr == CW'(MAX_WIDTH - 1);
  assign status.interior   = (column_count >= CW'(2)) && (row_count >= RW'(2));
  assign status.root_last  = bitm[0];
  assign status.out_free   = !res_valid || res_ready;

  // Take configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FW_BITS'(RESET_FRAME_WIDTH);
      frame_height <= FH_BITS'(RESET_FRAME_HEIGHT);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:  frame_width  <= cfg_data[FW_BITS-1:0];
        REG_FRAME_HEIGHT: frame_height <= cfg_data[FH_BITS-1:0];
        default:          frame_width  <= frame_width;
      endcase
    end
  end

  // Sweep the line stores after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear && !status.clear_done) begin
      clr_addr <= clr_addr + CW'(1);
    end
  end

  // Restart on frame start, advance after each pixel
  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (cmd.load && frame_start) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (cmd.update) begin
      if (row_end) begin
        column_count <= '0;
        row_count    <= frame_end ? '0 : row_inc[RW-1:0];
      end else begin
        column_count <= col_inc[CW-1:0];
      end
    end
  end

  // Capture the transferred pixel
  always_ff @(posedge clk) begin
    if (cmd.load) pix_q <= pixel;
  end

  // Older line store: clear, read the row two up, write the row one up
  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      older_line[clr_addr] <= '0;
    end else if (cmd.update) begin
      older_line[column_count] <= mid_q;
    end
    if (cmd.read) top_q <= older_line[column_count];
  end

  // Newer line store: clear, read the row one up, write the current row
  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      newer_line[clr_addr] <= '0;
    end else if (cmd.update) begin
      newer_line[column_count] <= pix_q;
    end
    if (cmd.read) mid_q <= newer_line[column_count];
  end

  // Shift the window by one column
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 6; i++) win[i] <= '0;
    end else if (cmd.update) begin
      win[0] <= win[3];
      win[1] <= win[4];
      win[2] <= win[5];
      win[3] <= top_q;
      win[4] <= mid_q;
      win[5] <= pix_q;
    end
  end

  // Horizontal and vertical Sobel sums
  logic signed [GRAD_BITS:0] t1, t2, dd, bh, gh_c, gv_c;

  always_comb begin
    t1   = $signed({4'd0, win[0]}) - $signed({4'd0, pix_q});
    t2   = $signed({4'd0, top_q}) - $signed({4'd0, win[2]});
    dd   = $signed({4'd0, win[1]}) - $signed({4'd0, mid_q});
    bh   = $signed({4'd0, win[3]}) - $signed({4'd0, win[5]});
    gh_c = (dd <<< 1) + t1 - t2;
    gv_c = (bh <<< 1) + t1 + t2;
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      gh     <= gh_c[GRAD_BITS-1:0];
      gv     <= gv_c[GRAD_BITS-1:0];
      last_q <= frame_end && row_end;
    end
  end

  // Square both sums
  logic signed [2*GRAD_BITS-1:0] sqh_full, sqv_full;

  assign sqh_full = gh * gh;
  assign sqv_full = gv * gv;

  always_ff @(posedge clk) begin
    if (cmd.square) begin
      sq_h <= sqh_full[SQ_BITS-1:0];
      sq_v <= sqv_full[SQ_BITS-1:0];
    end
  end

  // Integer square root of S << 16, two radicand bits per step
  logic [SUM_BITS-1:0] s_sum;
  logic [RAD_BITS:0]   trial;
  logic                take;

  assign s_sum = SUM_BITS'(sq_h) + SUM_BITS'(sq_v);
  assign trial = {1'b0, root} + {1'b0, bitm};
  assign take  = {1'b0, rem} >= trial;

  always_ff @(posedge clk) begin
    if (cmd.sum) begin
      rem  <= {s_sum, FRAC_BITS'(0)};
      root <= '0;
      bitm <= RAD_BITS'(1) << ROOT_TOP;
    end else if (cmd.root_step) begin
      if (take) begin
        rem  <= rem - trial[RAD_BITS-1:0];
        root <= (root >> 1) + bitm;
      end else begin
        root <= root >> 1;
      end
      bitm <= bitm >> 2;
    end
  end

  // Scale by 1/1140 through the reciprocal
  logic [ROOT_BITS+RECIP_BITS-1:0] scale_prod;

  assign scale_prod = root[ROOT_BITS-1:0] * RECIP_BITS'(RECIP);

  always_ff @(posedge clk) begin
    if (cmd.scale) q_est <= scale_prod[ROOT_BITS+RECIP_BITS-1:RECIP_SHIFT];
  end

  // Correct the quotient by one and clamp
  logic [Q_BITS+DIV_BITS-1:0] q_mul, rsd;
  logic [Q_BITS-1:0]          q_fix;

  always_comb begin
    q_mul = q_est * DIV_BITS'(SCALE_DIV);
    rsd   = (Q_BITS + DIV_BITS)'(root[ROOT_BITS-1:0]) - q_mul;
    q_fix = q_est + Q_BITS'(rsd >= (Q_BITS + DIV_BITS)'(SCALE_DIV));
  end

  always_ff @(posedge clk) begin
    if (cmd.fix) begin
      mag_q <= (q_fix > Q_BITS'(MAG_MAX)) ? PIX_BITS'(MAG_MAX) : q_fix[PIX_BITS-1:0];
    end
  end

  // Output register: load on emit, drop after transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.emit) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      magnitude  <= mag_q;
      frame_last <= last_q;
    end
  end

  // A root step always has a radicand bit left to work on
  a_root_bit: assert property (@(posedge clk) disable iff (rst)
    cmd.root_step |-> bitm != '0)
    else $error("root step with no bit left");

  // The finished root fits the scaling multiplier
  a_root_range: assert property (@(posedge clk) disable iff (rst)
    (cmd.root_step && bitm[0]) |=> root[RAD_BITS-1:ROOT_BITS] == '0)
    else $error("root exceeds its range");

  // A result never overwrites one that waits
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |-> !cmd.emit)
    else $error("result overwritten while stalled");

  // No pixel is processed during the clearing sweep
  a_clear_excl: assert property (@(posedge clk) disable iff (rst)
    cmd.clear |-> !(cmd.update || cmd.read || cmd.load))
    else $error("pixel work during line store sweep");

endmodule

`default_nettype wire

@@ design/sobel_edge_magnitude.sv @@
// Top level of the Sobel edge magnitude block: controller, datapath and channels.
//
// Grey pixels come in raster order; each interior pixel gives one magnitude
// min(255, floor(isqrt(S << 16) / 1140)) with S the sum of the squared Sobel
// sums, when the pixel below and to the right of it arrives, and frame_last
// marks the last interior pixel of a frame. A pixel that gives no result
// passes through accept, line store read and window update; one that gives a
// result goes on through squaring, summing, the square root unit that resolves
// one root bit per cycle, scaling, correction and emit. The result sits in an
// output register so the next pixel is taken while it waits, unless a further
// result is ready before it is transferred. After reset all MAX_WIDTH entries
// of the line stores (2048 by default) are cleared, during which no pixel is
// accepted; configuration writes are taken at any time.
`default_nettype none

module sobel_edge_magnitude import sem_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  wire        clk,
  input  wire        rst,
  sem_pix_if.sink    pixels,
  sem_res_if.source  results,
  sem_cfg_if.sink    cfg
);

  dp_cmd_t    cmd;
  dp_status_t status;

  // Configuration writes are always taken
  assign cfg.ready = 1'b1;

  sem_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .pix_valid (pixels.valid),
    .pix_ready (pixels.ready),
    .status    (status),
    .cmd       (cmd)
  );

  sem_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .pixel       (pixels.pixel),
    .frame_start (pixels.frame_start),
    .cfg_valid   (cfg.valid),
    .cfg_index   (cfg.index),
    .cfg_data    (cfg.data),
    .res_ready   (results.ready),
    .res_valid   (results.valid),
    .magnitude   (results.magnitude),
    .frame_last  (results.frame_last)
  );

endmodule

`default_nettype wire

@@ tb/tb_sobel_edge_magnitude.sv @@
// Self-checking testbench of the Sobel edge magnitude block with a predictor of its own.
`timescale 1ns / 100ps

module tb_sobel_edge_magnitude;
  import sem_pkg::*;

  localparam int CYCLE_LIMIT = 4_000_000;
  localparam int TAIL_CYCLES = 60;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES = 400;

  // Pixel content styles of generated frames
  typedef enum int {
    STYLE_NOISE,
    STYLE_BINARY,
    STYLE_RAMP,
    STYLE_STRIPES
  } pix_style_t;

  typedef struct packed {
    logic [PIX_BITS-1:0] magnitude;
    logic                frame_last;
  } mag_result_t;

  logic clk;
  logic rst;

  sem_pix_if pix_ch();
  sem_res_if res_ch();
  sem_cfg_if cfg_ch();

  sobel_edge_magnitude uut (
    .clk     (clk),
    .rst     (rst),
    .pixels  (pix_ch),
    .results (res_ch),
    .cfg     (cfg_ch)
  );

  // Predictor state: line stores, window, position and register copies
  logic [PIX_BITS-1:0] row_above2 [DEF_MAX_WIDTH];
  logic [PIX_BITS-1:0] row_above1 [DEF_MAX_WIDTH];
  logic [PIX_BITS-1:0] win_cols [6];
  int unsigned col_pos;
  int unsigned row_pos;
  logic [FW_BITS-1:0] width_copy;
  logic [FH_BITS-1:0] height_copy;

  mag_result_t pending_mags [$];
  int mismatch_count;
  int cycle_count;
  int send_idle_pct;
  int recv_stall_pct;
  bit hold_off;

  always #2 clk = ~clk;

  function automatic int unsigned eff_size(int unsigned v, int unsigned hi);
    if (v < MIN_SIZE) return MIN_SIZE;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic longint unsigned floor_root(longint unsigned v);
    longint unsigned r;
    longint unsigned t;
    r = 0;
    for (int b = 19; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= v) r = t;
    end
    return r;
  endfunction

  // Work out the magnitude caused by one accepted pixel, if any
  task predict_pixel(input logic [PIX_BITS-1:0] px, input logic fs);
    int unsigned w, h, idx;
    int signed top, mid, bot, a, d, g, b, hb, t1, t2, gh, gv;
    longint unsigned energy, mag;
    mag_result_t res;
    w = eff_size(width_copy, DEF_MAX_WIDTH);
    h = eff_size(height_copy, DEF_MAX_HEIGHT);
    if (fs) begin
      col_pos = 0;
      row_pos = 0;
    end
    idx = col_pos % DEF_MAX_WIDTH;
    top = row_above2[idx];
    mid = row_above1[idx];
    bot = px;
    if (row_pos >= 2 && col_pos >= 2) begin
      a  = win_cols[0];
      d  = win_cols[1];
      g  = win_cols[2];
      b  = win_cols[3];
      hb = win_cols[5];
      t1 = a - bot;
      t2 = top - g;
      gh = 2 * (d - mid) + t1 - t2;
      gv = 2 * (b - hb) + t1 + t2;
      energy = gh * gh + gv * gv;
      mag = floor_root(energy << FRAC_BITS) / SCALE_DIV;
      if (mag > MAG_MAX) mag = MAG_MAX;
      res.magnitude  = mag[PIX_BITS-1:0];
      res.frame_last = (row_pos + 1 >= h) && (col_pos + 1 >= w);
      pending_mags.push_back(res);
    end
    row_above2[idx] = mid[PIX_BITS-1:0];
    row_above1[idx] = px;
    win_cols[0] = win_cols[3];
    win_cols[1] = win_cols[4];
    win_cols[2] = win_cols[5];
    win_cols[3] = top[PIX_BITS-1:0];
    win_cols[4] = mid[PIX_BITS-1:0];
    win_cols[5] = px;
    // Advance the raster position, wrapping row and frame
    if (col_pos + 1 >= w) begin
      col_pos = 0;
      row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
    end else begin
      col_pos = col_pos + 1;
    end
  endtask

  task report_mismatch(input string what, input mag_result_t want, input mag_result_t got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("mismatch (%s) at cycle %0d: expected mag=%0d last=%0b, got mag=%0d last=%0b",
               what, cycle_count, want.magnitude, want.frame_last, got.magnitude,
               got.frame_last);
  endtask

  // Check results, predict pixels and track register writes at each edge
  always @(posedge clk) begin
    mag_result_t got;
    mag_result_t want;
    if (!rst) begin
      if (res_ch.valid && res_ch.ready) begin
        got.magnitude  = res_ch.magnitude;
        got.frame_last = res_ch.frame_last;
        if (pending_mags.size() == 0) begin
          want = '0;
          report_mismatch("unexpected result", want, got);
        end else begin
          want = pending_mags.pop_front();
          if (got.magnitude !== want.magnitude || got.frame_last !== want.frame_last)
            report_mismatch("wrong field", want, got);
        end
      end
      if (pix_ch.valid && pix_ch.ready)
        predict_pixel(pix_ch.pixel, pix_ch.frame_start);
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          REG_FRAME_WIDTH:  width_copy = cfg_ch.data[FW_BITS-1:0];
          REG_FRAME_HEIGHT: height_copy = cfg_ch.data[FH_BITS-1:0];
          default: ;
        endcase
      end
    end
  end

  // Drive result ready: random stalls, or held low during a hold-off
  always @(negedge clk) begin
    if (hold_off)
      res_ch.ready <= 1'b0;
    else
      res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Guard against a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic logic [PIX_BITS-1:0] pattern_pixel(pix_style_t style, int c, int r);
    case (style)
      STYLE_BINARY:  return $urandom_range(1) ? 8'hFF : 8'h00;
      STYLE_RAMP:    return 8'(c * 37 + r * 11);
      STYLE_STRIPES: return 8'(r * 64 + $urandom_range(3));
      default:       return 8'($urandom_range(255));
    endcase
  endfunction

  // Offer one pixel and hold it until transfer; called and returns at a falling edge
  task send_pixel(input logic [PIX_BITS-1:0] px, input logic fs);
    while ($urandom_range(99) < send_idle_pct) begin
      pix_ch.valid <= 1'b0;
      @(negedge clk);
    end
    pix_ch.valid       <= 1'b1;
    pix_ch.pixel       <= px;
    pix_ch.frame_start <= fs;
    do @(posedge clk); while (!pix_ch.ready);
    @(negedge clk);
  endtask

  task send_frame(input int cols, input int rows, input int count, input pix_style_t style,
                  input bit noisy);
    logic fs;
    for (int i = 0; i < count; i++) begin
      fs = (i == 0) || (noisy && $urandom_range(15) == 0);
      send_pixel(pattern_pixel(style, i % cols, (i / cols) % rows), fs);
    end
  endtask

  // Drop valid, drain all expected results, then let in-flight pixels finish
  task settle();
    pix_ch.valid <= 1'b0;
    while (pending_mags.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task write_reg(input cfg_reg_t idx, input logic [CFG_DATA_BITS-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    @(negedge clk);
  endtask

  // Extreme pixel values: full-swing edges between 0 and 255
  task test_directed_patterns();
    logic [PIX_BITS-1:0] vals [20];
    vals = '{8'd0,   8'd255, 8'd0,   8'd255, 8'd0,
             8'd255, 8'd255, 8'd255, 8'd0,   8'd0,
             8'd0,   8'd0,   8'd0,   8'd255, 8'd255,
             8'd255, 8'd0,   8'd255, 8'd0,   8'd255};
    write_reg(REG_FRAME_WIDTH, 13'd5);
    write_reg(REG_FRAME_HEIGHT, 13'd4);
    for (int i = 0; i < 20; i++)
      send_pixel(vals[i], i == 0);
    settle();
  endtask

  // Sizes below the minimum, frame wrap without frame_start, restart mid-frame
  task test_size_clamp();
    write_reg(REG_FRAME_WIDTH, 13'd0);
    write_reg(REG_FRAME_HEIGHT, 13'd2);
    send_frame(3, 3, 18, STYLE_NOISE, 1'b0);
    settle();
    write_reg(REG_FRAME_WIDTH, 13'd4);
    write_reg(REG_FRAME_HEIGHT, 13'd4);
    send_frame(4, 4, 6, STYLE_BINARY, 1'b0);
    send_frame(4, 4, 16, STYLE_NOISE, 1'b0);
    settle();
  endtask

  // Shrink width and height while the counters sit past the new limits
  task test_mid_frame_resize();
    write_reg(REG_FRAME_WIDTH, 13'd6);
    write_reg(REG_FRAME_HEIGHT, 13'd6);
    send_frame(6, 6, 16, STYLE_NOISE, 1'b0);
    settle();
    write_reg(REG_FRAME_WIDTH, 13'd3);
    for (int i = 0; i < 20; i++)
      send_pixel(8'($urandom_range(255)), 1'b0);
    settle();
    write_reg(REG_FRAME_HEIGHT, 13'd3);
    for (int i = 0; i < 12; i++)
      send_pixel(8'($urandom_range(255)), 1'b0);
    settle();
  endtask

  // Hold the result side off for a long stretch while pixels keep coming
  task test_output_hold_off();
    write_reg(REG_FRAME_WIDTH, 13'd8);
    write_reg(REG_FRAME_HEIGHT, 13'd6);
    fork
      begin
        @(posedge clk);
        hold_off = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off = 1'b0;
      end
    join_none
    send_frame(8, 6, 48, STYLE_NOISE, 1'b0);
    settle();
  endtask

  // Random sizes and frames: mostly complete frames, some cut short or restarted
  task test_random_frames(input int n_items, input int send_pct, input int recv_pct);
    int sent, cols, rows, count, mode;
    logic [CFG_DATA_BITS-1:0] wdata, hdata;
    pix_style_t style;
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    sent = 0;
    while (sent < n_items) begin
      settle();
      if ($urandom_range(6) == 0) begin
        wdata = 13'($urandom_range(8191));
        hdata = 13'($urandom_range(8191));
      end else begin
        wdata = 13'($urandom_range(12));
        hdata = 13'($urandom_range(10));
      end
      write_reg(REG_FRAME_WIDTH, wdata);
      write_reg(REG_FRAME_HEIGHT, hdata);
      cols = eff_size(wdata[FW_BITS-1:0], DEF_MAX_WIDTH);
      rows = eff_size(hdata, DEF_MAX_HEIGHT);
      repeat ($urandom_range(1, 3)) begin
        mode  = $urandom_range(9);
        count = cols * rows;
        if (count > 80) count = 80;
        if (mode == 0) count = $urandom_range(1, count);
        style = pix_style_t'($urandom_range(3));
        send_frame(cols, rows, count, style, mode == 1);
        sent += count;
      end
    end
    settle();
  endtask

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    pix_ch.valid       = 1'b0;
    pix_ch.pixel       = '0;
    pix_ch.frame_start = 1'b0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.index       = REG_FRAME_WIDTH;
    cfg_ch.data        = '0;
    res_ch.ready       = 1'b0;
    hold_off       = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    mismatch_count = 0;
    cycle_count    = 0;
    for (int i = 0; i < DEF_MAX_WIDTH; i++) begin
      row_above2[i] = '0;
      row_above1[i] = '0;
    end
    for (int i = 0; i < 6; i++) win_cols[i] = '0;
    col_pos     = 0;
    row_pos     = 0;
    width_copy  = FW_BITS'(RESET_FRAME_WIDTH);
    height_copy = FH_BITS'(RESET_FRAME_HEIGHT);

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_directed_patterns();
    test_size_clamp();
    test_mid_frame_resize();
    test_output_hold_off();
    test_random_frames(450, 0, 0);
    test_random_frames(450, 53, 0);
    test_random_frames(450, 0, 53);
    test_random_frames(450, 27, 27);

    // Drain and let the pipeline run dry before the verdict
    pix_ch.valid <= 1'b0;
    while (pending_mags.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_mags.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
